// File: design/pod_pkg.sv
// ----------------------------------------------------------------------------
// pod_pkg
// Shared types, constants and pattern functions for the 2bpp ordered dither.
// ----------------------------------------------------------------------------
package pod_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int GRAY_LEVELS         = 49;
    localparam int IDX_W               = 8;
    localparam int LEVEL_W             = 6;

    localparam logic [15:0] LUMA_R_W = 16'd19595;
    localparam logic [15:0] LUMA_G_W = 16'd38470;
    localparam logic [15:0] LUMA_B_W = 16'd7471;

    localparam logic [7:0] MASK_HI_NIB = 8'hf0;
    localparam logic [7:0] MASK_LO_NIB = 8'h0f;
    localparam logic [7:0] MASK_COL0   = 8'hc0;
    localparam logic [7:0] MASK_COL1   = 8'h30;
    localparam logic [7:0] MASK_COL2   = 8'h0c;
    localparam logic [7:0] MASK_COL3   = 8'h03;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    localparam logic [1:0] MODE_ROW4 = 2'd0;
    localparam logic [1:0] MODE_PAIR = 2'd1;
    localparam logic [1:0] MODE_QUAD = 2'd2;

    localparam logic [1:0] CELL_X [16] = '{2'd0, 2'd2, 2'd2, 2'd0, 2'd1, 2'd3, 2'd3, 2'd1,
                                           2'd1, 2'd3, 2'd3, 2'd1, 2'd0, 2'd2, 2'd2, 2'd0};
    localparam logic [1:0] CELL_Y [16] = '{2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd3, 2'd1, 2'd3,
                                           2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd3, 2'd1, 2'd3};

    typedef struct packed {
        logic       func;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] pixel_a;
        logic [7:0] pixel_b;
        logic [7:0] pixel_c;
        logic [7:0] pixel_d;
        logic [1:0] line_phase;
    } pod_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } pod_out_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } pod_adv_t;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   index;
        logic [LEVEL_W-1:0] level;
    } pod_wr_t;

    function automatic logic [LEVEL_W-1:0] default_level(input logic [IDX_W-1:0] idx);
        logic [13:0] prod;
        prod = 14'(idx) * 14'(GRAY_LEVELS);
        return prod[13:8];
    endfunction

    function automatic logic [3:0][7:0] pattern_rows(input logic [LEVEL_W-1:0] level);
        logic [LEVEL_W-1:0] lv;
        logic [LEVEL_W-1:0] lm1;
        logic [1:0]         g;
        logic [3:0]         o;
        logic [1:0]         v;
        logic [3:0][7:0]    rows;
        rows = '0;
        lv   = (level > LEVEL_W'(GRAY_LEVELS - 1)) ? LEVEL_W'(GRAY_LEVELS - 1) : level;
        lm1  = lv - LEVEL_W'(1);
        g    = lm1[5:4] + 2'd1;
        o    = lm1[3:0];
        if (lv != '0)
        begin
            for (int k = 0; k < 16; k++)
            begin
                v = (4'(k) <= o) ? g : g - 2'd1;
                rows[CELL_Y[k]][2*CELL_X[k] +: 2] = v;
            end
        end
        return rows;
    endfunction

endpackage

// File: design/pod_luma.sv
// ----------------------------------------------------------------------------
// pod_luma
// Three-stage RGB to gray level conversion: weight products, sum, scale.
// ----------------------------------------------------------------------------
module pod_luma
(
    input  logic                        clk,
    input  pod_pkg::pod_adv_t           adv,
    input  logic [7:0]                  red,
    input  logic [7:0]                  green,
    input  logic [7:0]                  blue,
    output logic [pod_pkg::LEVEL_W-1:0] level
);

    logic [22:0]                 pr_reg;
    logic [23:0]                 pg_reg;
    logic [20:0]                 pb_reg;
    logic [23:0]                 y_reg;
    logic [23:0]                 y_next;
    logic [29:0]                 scaled;
    logic [pod_pkg::LEVEL_W-1:0] level_reg;
    logic [pod_pkg::LEVEL_W-1:0] level_next;

    assign y_next = 24'(pr_reg) + pg_reg + 24'(pb_reg);
    assign scaled = 30'(y_reg) * 30'(pod_pkg::GRAY_LEVELS);

    always_comb
    begin
        if (scaled[29:24] > pod_pkg::LEVEL_W'(pod_pkg::GRAY_LEVELS - 1))
            level_next = pod_pkg::LEVEL_W'(pod_pkg::GRAY_LEVELS - 1);
        else
            level_next = scaled[29:24];
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            pr_reg <= 23'(24'(red) * 24'(pod_pkg::LUMA_R_W));
            pg_reg <= 24'(green) * 24'(pod_pkg::LUMA_G_W);
            pb_reg <= 21'(24'(blue) * 24'(pod_pkg::LUMA_B_W));
        end
        if (adv.s2)
            y_reg <= y_next;
        if (adv.s3)
            level_reg <= level_next;
    end

    assign level = level_reg;

endmodule

// File: design/pod_lane.sv
// ----------------------------------------------------------------------------
// pod_lane
// One lookup lane: palette gray-level copy with registered read.
// ----------------------------------------------------------------------------
module pod_lane
#(
    parameter int PALETTE_ENTRIES = pod_pkg::PALETTE_ENTRIES_DEF
)
(
    input  logic                        clk,
    input  pod_pkg::pod_wr_t            wr,
    input  logic [PALETTE_ENTRIES-1:0]  filled,
    input  logic                        rd_en,
    input  logic [pod_pkg::IDX_W-1:0]   rd_index,
    output logic [pod_pkg::LEVEL_W-1:0] level
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic [pod_pkg::LEVEL_W-1:0] mem_reg [PALETTE_ENTRIES];
    logic [pod_pkg::LEVEL_W-1:0] q_reg;
    logic [pod_pkg::LEVEL_W-1:0] dflt_reg;
    logic                        hit_reg;
    logic                        range_reg;
    logic                        in_range;

    assign in_range = {1'b0, rd_index} < (pod_pkg::IDX_W + 1)'(PALETTE_ENTRIES);

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem_reg[wr.index[AW-1:0]] <= wr.level;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            q_reg     <= mem_reg[rd_index[AW-1:0]];
            dflt_reg  <= pod_pkg::default_level(rd_index);
            hit_reg   <= in_range ? filled[rd_index[AW-1:0]] : 1'b0;
            range_reg <= in_range;
        end
    end

    assign level = !range_reg ? '0 : (hit_reg ? q_reg : dflt_reg);

endmodule

// File: design/pod_merge.sv
// ----------------------------------------------------------------------------
// pod_merge
// Combine lane levels into row bytes and send one per cycle unless stalled.
// ----------------------------------------------------------------------------
module pod_merge
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic [1:0]                       mode,
    input  logic [1:0]                       phase,
    input  logic [3:0][pod_pkg::LEVEL_W-1:0] levels,
    output logic                             free,
    output logic                             res_valid,
    input  logic                             res_stall,
    output pod_pkg::pod_out_t                res_data
);

    logic [3:0][7:0] rows [4];
    logic [3:0][7:0] new_bytes;
    logic [1:0]      new_last;
    logic            new_has;
    logic [3:0][7:0] bytes_reg;
    logic [3:0][7:0] bytes_next;
    logic            valid_reg;
    logic            valid_next;
    logic [1:0]      pos_reg;
    logic [1:0]      pos_next;
    logic [1:0]      last_reg;
    logic [1:0]      last_next;
    logic            xfer;
    logic            at_last;
    logic [1:0]      r0;
    logic [1:0]      r1;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            rows[i] = pod_pkg::pattern_rows(levels[i]);
    end

    assign r0 = {phase[0], 1'b0};
    assign r1 = {phase[0], 1'b1};

    always_comb
    begin
        new_bytes = '0;
        new_last  = 2'd0;
        new_has   = 1'b1;
        unique case (mode)
            pod_pkg::MODE_ROW4:
            begin
                new_bytes = rows[0];
                new_last  = 2'd3;
            end
            pod_pkg::MODE_PAIR:
            begin
                new_bytes[0] = (rows[0][r0] & pod_pkg::MASK_HI_NIB)
                             | (rows[1][r0] & pod_pkg::MASK_LO_NIB);
                new_bytes[1] = (rows[0][r1] & pod_pkg::MASK_HI_NIB)
                             | (rows[1][r1] & pod_pkg::MASK_LO_NIB);
                new_last     = 2'd1;
            end
            pod_pkg::MODE_QUAD:
            begin
                new_bytes[0] = (rows[0][phase] & pod_pkg::MASK_COL0)
                             | (rows[1][phase] & pod_pkg::MASK_COL1)
                             | (rows[2][phase] & pod_pkg::MASK_COL2)
                             | (rows[3][phase] & pod_pkg::MASK_COL3);
                new_last     = 2'd0;
            end
            default:
                new_has = 1'b0;
        endcase
    end

    assign xfer    = valid_reg && !res_stall;
    assign at_last = pos_reg == last_reg;
    assign free    = !valid_reg || (xfer && at_last);

    always_comb
    begin
        valid_next = valid_reg;
        pos_next   = pos_reg;
        last_next  = last_reg;
        bytes_next = bytes_reg;
        if (xfer)
        begin
            if (at_last)
                valid_next = 1'b0;
            else
                pos_next = pos_reg + 2'd1;
        end
        if (load && new_has)
        begin
            valid_next = 1'b1;
            pos_next   = 2'd0;
            last_next  = new_last;
            bytes_next = new_bytes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= 2'd0;
            last_reg  <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

    assign res_valid         = valid_reg;
    assign res_data.out_byte = bytes_reg[pos_reg];
    assign res_data.last     = at_last;

endmodule

// File: design/palette_ordered_dither_2bpp.sv
// ----------------------------------------------------------------------------
// palette_ordered_dither_2bpp
// Palette gray-level store and 4x4 ordered dither to packed 2-bit cells.
// ----------------------------------------------------------------------------
// channel   | handshake                    | payload
// pix       | pix_valid / pix_stall        | pod_in_t  (load or pixel group)
// res       | res_valid / res_stall        | pod_out_t (row byte, last)
// mode      | mode_we                      | mode_wdata (output mode)
//
// One transfer leaves the result register per cycle while res_stall is low; a
// pixel item yields 4 bytes in mode 0, 2 in mode 1, 1 in mode 2; a load none.
// Pixel items pass s1, s2, s3, the lane read and result registers. Reset
// sets mode 0 and the default gray ramp; no clearing pass is needed. A stalled
// result holds the stages behind it only once they are all full.
// ----------------------------------------------------------------------------
module palette_ordered_dither_2bpp
#(
    parameter int PALETTE_ENTRIES = pod_pkg::PALETTE_ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  pod_pkg::pod_in_t  pix_data,
    output logic              res_valid,
    input  logic              res_stall,
    output pod_pkg::pod_out_t res_data,
    input  logic              mode_we,
    input  logic [1:0]        mode_wdata
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic [1:0]                       mode_reg;
    logic [PALETTE_ENTRIES-1:0]       filled_reg;
    pod_pkg::pod_in_t                 s1_reg;
    pod_pkg::pod_in_t                 s2_reg;
    pod_pkg::pod_in_t                 s3_reg;
    logic [1:0]                       s4_phase_reg;
    logic                             s1_v_reg;
    logic                             s2_v_reg;
    logic                             s3_v_reg;
    logic                             s4_v_reg;
    logic                             s1_go;
    logic                             s2_go;
    logic                             s3_go;
    logic                             s4_go;
    logic                             s1_open;
    logic                             s3_open;
    logic                             s4_open;
    logic                             s3_load;
    logic                             in_xfer;
    logic                             seq_free;
    logic                             rd_en;
    logic [pod_pkg::LEVEL_W-1:0]      load_level;
    logic [3:0][pod_pkg::IDX_W-1:0]   s3_pix;
    logic [3:0][pod_pkg::LEVEL_W-1:0] levels;
    pod_pkg::pod_adv_t                adv;
    pod_pkg::pod_wr_t                 wr;

    assign s3_load = s3_reg.func == pod_pkg::FUNC_LOAD;
    assign s4_go   = s4_v_reg && seq_free;
    assign s4_open = !s4_v_reg || s4_go;
    assign s3_go   = s3_v_reg && (s3_load || s4_open);
    assign s3_open = !s3_v_reg || s3_go;
    assign s2_go   = s2_v_reg && s3_open;
    assign s1_go   = s1_v_reg && (!s2_v_reg || s2_go);
    assign s1_open = !s1_v_reg || s1_go;
    assign in_xfer = pix_valid && s1_open;
    assign rd_en   = s3_go && !s3_load;

    assign pix_stall = !s1_open;

    assign adv.s1 = in_xfer;
    assign adv.s2 = s1_go;
    assign adv.s3 = s2_go;

    assign wr.en    = s3_go && s3_load
                   && ({1'b0, s3_reg.entry_index} < (pod_pkg::IDX_W + 1)'(PALETTE_ENTRIES));
    assign wr.index = s3_reg.entry_index;
    assign wr.level = load_level;

    assign s3_pix = {s3_reg.pixel_d, s3_reg.pixel_c, s3_reg.pixel_b, s3_reg.pixel_a};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= pod_pkg::MODE_ROW4;
            filled_reg <= '0;
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            s3_v_reg   <= 1'b0;
            s4_v_reg   <= 1'b0;
        end
        else
        begin
            if (mode_we)
                mode_reg <= mode_wdata;
            if (wr.en)
                filled_reg[wr.index[AW-1:0]] <= 1'b1;
            if (in_xfer)
                s1_v_reg <= 1'b1;
            else if (s1_go)
                s1_v_reg <= 1'b0;
            if (s1_go)
                s2_v_reg <= 1'b1;
            else if (s2_go)
                s2_v_reg <= 1'b0;
            if (s2_go)
                s3_v_reg <= 1'b1;
            else if (s3_go)
                s3_v_reg <= 1'b0;
            if (rd_en)
                s4_v_reg <= 1'b1;
            else if (s4_go)
                s4_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            s1_reg <= pix_data;
        if (s1_go)
            s2_reg <= s1_reg;
        if (s2_go)
            s3_reg <= s2_reg;
        if (rd_en)
            s4_phase_reg <= s3_reg.line_phase;
    end

    pod_luma u_luma
    (
        .clk   (clk),
        .adv   (adv),
        .red   (pix_data.red),
        .green (pix_data.green),
        .blue  (pix_data.blue),
        .level (load_level)
    );

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        pod_lane #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_lane
        (
            .clk      (clk),
            .wr       (wr),
            .filled   (filled_reg),
            .rd_en    (rd_en),
            .rd_index (s3_pix[i]),
            .level    (levels[i])
        );
    end

    pod_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s4_go),
        .mode      (mode_reg),
        .phase     (s4_phase_reg),
        .levels    (levels),
        .free      (seq_free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

// File: tb/palette_ordered_dither_2bpp_test.sv
// ----------------------------------------------------------------------------
// palette_ordered_dither_2bpp_test
// Self-checking bench for the palette ordered dither. A directed table covers
// the default ramp, the extreme gray levels, palette loads and every output
// mode, then random load/pixel traffic runs in phases of different modes.
// Each result transfer is checked against a cycle-free dither predictor, or
// literal table bytes, with random pixel gaps and random result stalls.
// ----------------------------------------------------------------------------
module palette_ordered_dither_2bpp_test;

    localparam logic [1:0] M_ROW4      = pod_pkg::MODE_ROW4;
    localparam logic [1:0] M_PAIR      = pod_pkg::MODE_PAIR;
    localparam logic [1:0] M_QUAD      = pod_pkg::MODE_QUAD;
    localparam logic [1:0] MODE_NONE   = 2'd3;
    localparam logic       F_LD        = pod_pkg::FUNC_LOAD;
    localparam logic       F_PX        = pod_pkg::FUNC_PIXEL;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         DIR_ROWS    = 24;
    localparam int         RAND_PHASES = 9;
    localparam int         PHASE_ITEMS = 20;
    localparam int         MAX_REPORTS = 100;

    localparam int SEQ_COL [16] = '{0, 2, 2, 0, 1, 3, 3, 1, 1, 3, 3, 1, 0, 2, 2, 0};
    localparam int SEQ_ROW [16] = '{0, 2, 0, 2, 1, 3, 1, 3, 0, 2, 0, 2, 1, 3, 1, 3};

    typedef struct packed {
        int          mode;
        int          func;
        int          idx;
        int          red;
        int          grn;
        int          blu;
        int          pa;
        int          pb;
        int          pc;
        int          pd;
        int          phase;
        int          nlit;
        logic [31:0] lit;
    } dir_row_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              pix_valid  = 1'b0;
    logic              pix_stall;
    pod_pkg::pod_in_t  pix_data   = '0;
    logic              res_valid;
    logic              res_stall  = 1'b0;
    pod_pkg::pod_out_t res_data;
    logic              mode_we    = 1'b0;
    logic [1:0]        mode_wdata = 2'd0;

    logic [pod_pkg::LEVEL_W-1:0] gray_table [256];
    logic [1:0]                  cur_mode;
    pod_pkg::pod_out_t           pending_bytes [$];
    bit                          calm = 1'b0;
    int                          stall_left = 0;
    int                          err_count = 0;
    int                          cycle_count = 0;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{M_ROW4, F_PX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 4, 32'h00000000},
        '{M_ROW4, F_PX, 0, 0, 0, 0, 255, 0, 0, 0, 0, 4, 32'hffffffff},
        '{M_ROW4, F_PX, 0, 0, 0, 0, 6, 0, 0, 0, 0, 4, 32'h01000000},
        '{M_ROW4, F_PX, 0, 0, 0, 0, 128, 0, 0, 0, 1, 0, 32'h0},
        '{M_ROW4, F_LD, 7, 255, 255, 255, 0, 0, 0, 0, 0, 0, 32'h0},
        '{M_ROW4, F_PX, 0, 0, 0, 0, 7, 0, 0, 0, 0, 4, 32'hffffffff},
        '{M_ROW4, F_LD, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0},
        '{M_ROW4, F_PX, 0, 0, 0, 0, 255, 0, 0, 0, 3, 4, 32'h00000000},
        '{M_ROW4, F_LD, 0, 255, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0},
        '{M_ROW4, F_LD, 1, 0, 255, 0, 0, 0, 0, 0, 0, 0, 32'h0},
        '{M_ROW4, F_LD, 2, 0, 0, 255, 0, 0, 0, 0, 0, 0, 32'h0},
        '{M_ROW4, F_PX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0},
        '{M_ROW4, F_PX, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 32'h0},
        '{M_ROW4, F_PX, 0, 0, 0, 0, 2, 0, 0, 0, 0, 0, 32'h0},
        '{M_PAIR, F_PX, 0, 0, 0, 0, 7, 255, 0, 0, 0, 2, 32'hf0f00000},
        '{M_PAIR, F_PX, 0, 0, 0, 0, 255, 7, 0, 0, 3, 2, 32'h0f0f0000},
        '{M_PAIR, F_PX, 0, 0, 0, 0, 128, 200, 0, 0, 2, 0, 32'h0},
        '{M_QUAD, F_PX, 0, 0, 0, 0, 7, 255, 7, 255, 0, 1, 32'hcc000000},
        '{M_QUAD, F_PX, 0, 0, 0, 0, 255, 7, 255, 7, 3, 1, 32'h33000000},
        '{M_QUAD, F_PX, 0, 0, 0, 0, 60, 120, 180, 240, 1, 0, 32'h0},
        '{MODE_NONE, F_PX, 0, 0, 0, 0, 7, 0, 0, 0, 0, 0, 32'h0},
        '{MODE_NONE, F_LD, 9, 10, 200, 30, 0, 0, 0, 0, 0, 0, 32'h0},
        '{M_ROW4, F_PX, 0, 0, 0, 0, 9, 0, 0, 0, 0, 0, 32'h0},
        '{M_ROW4, F_PX, 0, 0, 0, 0, 3, 0, 0, 0, 2, 0, 32'h0}
    };

    palette_ordered_dither_2bpp u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix_data   (pix_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [pod_pkg::LEVEL_W-1:0] luma_level(input logic [7:0] r,
                                                               input logic [7:0] g,
                                                               input logic [7:0] b);
        logic [63:0] y;
        y = 64'(r) * 64'd19595 + 64'(g) * 64'd38470 + 64'(b) * 64'd7471;
        y = (y * 64'd49) >> 24;
        if (y > 64'd48)
            y = 64'd48;
        return pod_pkg::LEVEL_W'(y);
    endfunction

    function automatic logic [7:0] pattern_byte(input logic [pod_pkg::LEVEL_W-1:0] level,
                                                input int row);
        logic [7:0] acc;
        int         lv;
        int         g;
        int         o;
        acc = '0;
        lv  = (level > 48) ? 48 : int'(level);
        if (lv != 0)
        begin
            g = (lv - 1) / 16 + 1;
            o = (lv - 1) % 16;
            for (int k = 0; k < 16; k++)
            begin
                if (SEQ_ROW[k] == row)
                    acc[2*SEQ_COL[k] +: 2] = (k <= o) ? 2'(g) : 2'(g - 1);
            end
        end
        return acc;
    endfunction

    function automatic int predict_dither(input pod_pkg::pod_in_t item,
                                          output logic [3:0][7:0] bytes);
        int n;
        int base;
        bytes = '0;
        n     = 0;
        if (item.func == pod_pkg::FUNC_LOAD)
            gray_table[item.entry_index] = luma_level(item.red, item.green, item.blue);
        else
        begin
            case (cur_mode)
                pod_pkg::MODE_ROW4:
                begin
                    for (int k = 0; k < 4; k++)
                        bytes[k] = pattern_byte(gray_table[item.pixel_a], k);
                    n = 4;
                end
                pod_pkg::MODE_PAIR:
                begin
                    base = 2 * int'(item.line_phase[0]);
                    for (int k = 0; k < 2; k++)
                        bytes[k] = (pattern_byte(gray_table[item.pixel_a], base + k)
                                    & pod_pkg::MASK_HI_NIB)
                                 | (pattern_byte(gray_table[item.pixel_b], base + k)
                                    & pod_pkg::MASK_LO_NIB);
                    n = 2;
                end
                pod_pkg::MODE_QUAD:
                begin
                    base = int'(item.line_phase);
                    bytes[0] = (pattern_byte(gray_table[item.pixel_a], base)
                                & pod_pkg::MASK_COL0)
                             | (pattern_byte(gray_table[item.pixel_b], base)
                                & pod_pkg::MASK_COL1)
                             | (pattern_byte(gray_table[item.pixel_c], base)
                                & pod_pkg::MASK_COL2)
                             | (pattern_byte(gray_table[item.pixel_d], base)
                                & pod_pkg::MASK_COL3);
                    n = 1;
                end
                default:
                    n = 0;
            endcase
        end
        return n;
    endfunction

    function automatic logic [7:0] rand_channel();
        logic [7:0] v;
        case ($urandom_range(0, 5))
            0:       v = 8'h00;
            1:       v = 8'hff;
            default: v = 8'($urandom);
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_REPORTS)
            $display("mismatch %s: got 0x%0h want 0x%0h (cycle %0d)", what, got, want,
                     cycle_count);
        err_count++;
    endtask

    task automatic send_item(input pod_pkg::pod_in_t item, input int nlit,
                             input logic [31:0] lit);
        int                w;
        int                n;
        logic [3:0][7:0]   bytes;
        pod_pkg::pod_out_t res;
        w = calm ? 0 : $urandom_range(0, 4);
        if (w > 0)
        begin
            pix_valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= item;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        n = predict_dither(item, bytes);
        if (nlit > 0)
        begin
            n = nlit;
            for (int k = 0; k < nlit; k++)
                bytes[k] = lit[31 - 8*k -: 8];
        end
        for (int k = 0; k < n; k++)
        begin
            res.out_byte = bytes[k];
            res.last     = (k == n - 1);
            pending_bytes.push_back(res);
        end
    endtask

    task automatic settle(input int extra);
        pix_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_bytes.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_mode(input logic [1:0] m);
        settle(12);
        mode_we    <= 1'b1;
        mode_wdata <= m;
        @(posedge clk);
        mode_we    <= 1'b0;
        cur_mode = m;
    endtask

    always @(posedge clk)
    begin : res_side
        pod_pkg::pod_out_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_bytes.size() == 0)
                report_mismatch("unexpected transfer", int'(res_data), 0);
            else
            begin
                want = pending_bytes.pop_front();
                if (res_data.out_byte !== want.out_byte)
                    report_mismatch("out_byte", int'(res_data.out_byte), int'(want.out_byte));
                if (res_data.last !== want.last)
                    report_mismatch("last", int'(res_data.last), int'(want.last));
            end
            stall_left = calm ? 0 : $urandom_range(0, 4);
        end
        if (rst_n && stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left--;
        end
        else
            res_stall <= 1'b0;
    end

    initial
    begin : stimulus
        pod_pkg::pod_in_t item;
        dir_row_t         row;
        logic [1:0]       phase_mode;
        int               pause_at;
        for (int i = 0; i < 256; i++)
            gray_table[i] = pod_pkg::LEVEL_W'((i * pod_pkg::GRAY_LEVELS) / 256);
        cur_mode = pod_pkg::MODE_ROW4;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_mode(pod_pkg::MODE_ROW4);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = dir_table[i];
            if (2'(row.mode) != cur_mode)
                set_mode(2'(row.mode));
            item.func        = 1'(row.func);
            item.entry_index = 8'(row.idx);
            item.red         = 8'(row.red);
            item.green       = 8'(row.grn);
            item.blue        = 8'(row.blu);
            item.pixel_a     = 8'(row.pa);
            item.pixel_b     = 8'(row.pb);
            item.pixel_c     = 8'(row.pc);
            item.pixel_d     = 8'(row.pd);
            item.line_phase  = 2'(row.phase);
            send_item(item, row.nlit, row.lit);
        end

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0:       phase_mode = pod_pkg::MODE_ROW4;
                1:       phase_mode = pod_pkg::MODE_PAIR;
                2:       phase_mode = pod_pkg::MODE_QUAD;
                3:       phase_mode = MODE_NONE;
                default: phase_mode = 2'($urandom_range(0, 2));
            endcase
            set_mode(phase_mode);
            calm     = (p == 1) || ($urandom_range(0, 4) == 0);
            pause_at = (p == 2) ? PHASE_ITEMS / 2 : $urandom_range(0, 3 * PHASE_ITEMS);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == pause_at)
                    settle(0);
                item.func        = ($urandom_range(0, 9) < 3) ? pod_pkg::FUNC_LOAD
                                                              : pod_pkg::FUNC_PIXEL;
                item.entry_index = 8'($urandom);
                item.red         = rand_channel();
                item.green       = rand_channel();
                item.blue        = rand_channel();
                item.pixel_a     = 8'($urandom);
                item.pixel_b     = 8'($urandom);
                item.pixel_c     = 8'($urandom);
                item.pixel_d     = 8'($urandom);
                item.line_phase  = 2'($urandom);
                send_item(item, 0, 32'h0);
            end
        end

        calm = 1'b0;
        settle(20);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
design/pod_pkg.sv
design/pod_luma.sv
design/pod_lane.sv
design/pod_merge.sv
design/palette_ordered_dither_2bpp.sv
tb/palette_ordered_dither_2bpp_test.sv
